@@ rtl/v3a_pkg.sv @@
`default_nettype none

package v3a_pkg;

    // Fixed field widths
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 3;

    // Square root pipeline: one result bit per stage
    localparam int SQ_STAGES = PROD_W / 2;
    localparam int SQ_REM_W  = DATA_W + 3;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_DOT   = 4'd2,
        CMD_CROSS = 4'd3,
        CMD_SCALE = 4'd4,
        CMD_DIV   = 4'd5,
        CMD_LEN   = 4'd6,
        CMD_NORM  = 4'd7,
        CMD_EQ    = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_ZERONORM = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } sat_res_t;

    // Sideband carried along the square root and divide stages
    typedef struct packed {
        cmd_t                         cmd;
        logic [LANES-1:0][DATA_W-1:0] r;
        logic [DATA_W-1:0]            s;
        logic                         sat;
        logic [LANES-1:0][DATA_W-1:0] a;
        logic [DATA_W-1:0]            f;
        logic [DATA_W-1:0]            len;
        logic                         sq_zero;
    } side_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic sat_res_t sat32(input logic signed [SUM_W-1:0] v);
        sat_res_t res;
        logic     fits;
        fits = (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}});
        res.sat = !fits;
        if (fits)
        begin
            res.val = v[DATA_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            res.val = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res.val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/v3a_lane.sv @@
`default_nettype none

module v3a_lane #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire v3a_pkg::cmd_t                         cmd,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     a_self,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     a_p,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     a_q,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     b_self,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     b_p,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     b_q,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]     factor,
    output logic signed [v3a_pkg::PROD_W-1:0]          prod,
    output logic        [v3a_pkg::DATA_W-1:0]          elem,
    output logic                                       elem_sat
);

    localparam int DW = v3a_pkg::DATA_W;
    localparam int PW = v3a_pkg::PROD_W;
    localparam int SW = v3a_pkg::SUM_W;

    logic signed [DW-1:0] x0;
    logic signed [DW-1:0] y0;
    logic signed [PW-1:0] p0_next;
    logic signed [PW-1:0] p1_next;
    logic signed [PW-1:0] p0_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;
    v3a_pkg::cmd_t        cmd_reg;
    logic signed [SW-1:0] wide;
    v3a_pkg::sat_res_t    res;
    logic [DW-1:0]        elem_reg;
    logic                 sat_reg;

    // Pick multiplier operands for the command
    always_comb
    begin
        x0 = (cmd == v3a_pkg::CMD_CROSS) ? a_p : a_self;
        case (cmd)
            v3a_pkg::CMD_DOT:   y0 = b_self;
            v3a_pkg::CMD_SCALE: y0 = factor;
            v3a_pkg::CMD_CROSS: y0 = b_q;
            default:            y0 = a_self;
        endcase
    end

    assign p0_next = x0 * y0;
    assign p1_next = a_q * b_p;

    // Product stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            a_reg   <= a_self;
            b_reg   <= b_self;
            cmd_reg <= cmd;
        end
    end

    // Element-wise result before clamping
    always_comb
    begin
        case (cmd_reg)
            v3a_pkg::CMD_ADD:
                wide = $signed({{(SW-DW){a_reg[DW-1]}}, a_reg})
                     + $signed({{(SW-DW){b_reg[DW-1]}}, b_reg});
            v3a_pkg::CMD_SUB:
                wide = $signed({{(SW-DW){a_reg[DW-1]}}, a_reg})
                     - $signed({{(SW-DW){b_reg[DW-1]}}, b_reg});
            v3a_pkg::CMD_CROSS:
                wide = ($signed({{(SW-PW){p0_reg[PW-1]}}, p0_reg})
                      - $signed({{(SW-PW){p1_reg[PW-1]}}, p1_reg})) >>> FRAC_BITS;
            v3a_pkg::CMD_SCALE:
                wide = $signed({{(SW-PW){p0_reg[PW-1]}}, p0_reg}) >>> FRAC_BITS;
            default:
                wide = '0;
        endcase
        res = v3a_pkg::sat32(wide);
    end

    // Element result stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            elem_reg <= res.val;
            sat_reg  <= res.sat;
        end
    end

    assign prod     = p0_reg;
    assign elem     = elem_reg;
    assign elem_sat = sat_reg;

endmodule

`default_nettype wire

@@ rtl/v3a_sqrt.sv @@
`default_nettype none

module v3a_sqrt (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [v3a_pkg::PROD_W-1:0]    n,
    output logic      [v3a_pkg::DATA_W-1:0]    root
);

    localparam int NS = v3a_pkg::SQ_STAGES;
    localparam int RW = v3a_pkg::SQ_REM_W;
    localparam int PW = v3a_pkg::PROD_W;
    localparam int DW = v3a_pkg::DATA_W;

    logic [RW-1:0] rem_reg  [NS];
    logic [DW-1:0] root_reg [NS];
    logic [PW-1:0] n_reg    [NS];

    // One root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [DW-1:0] root_in;
        logic [PW-1:0] n_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = n;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign n_in    = n_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-3:0], n_in[PW-1:PW-2]};
        assign trial  = {{(RW-DW-2){1'b0}}, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[DW-2:0], ge};
                n_reg[k]    <= {n_in[PW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[NS-1];

endmodule

`default_nettype wire

@@ rtl/v3a_lane_div.sv @@
`default_nettype none

module v3a_lane_div #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         en,
    input  wire logic signed [v3a_pkg::DATA_W-1:0]            num,
    input  wire logic        [v3a_pkg::DATA_W-1:0]            den_mag,
    input  wire logic                                         den_neg,
    output logic [v3a_pkg::DATA_W+FRAC_BITS-1:0]              quot,
    output logic                                              neg
);

    localparam int DW = v3a_pkg::DATA_W;
    localparam int QW = DW + FRAC_BITS;

    logic [DW-1:0] num_mag;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [QW-1:0] d_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic          neg_reg  [QW];

    assign num_mag = num[DW-1] ? (~num + 1'b1) : num;

    // Restoring divide, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [QW-1:0] d_in;
        logic [DW-1:0] den_in;
        logic          neg_in;
        logic [DW:0]   rem_sh;
        logic [DW:0]   rem_sub;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign d_in   = {num_mag, {FRAC_BITS{1'b0}}};
            assign den_in = den_mag;
            assign neg_in = num[DW-1] ^ den_neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign rem_sh  = {rem_in, d_in[QW-1]};
        assign ge      = (rem_sh >= {1'b0, den_in});
        assign rem_sub = rem_sh - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                q_reg[k]   <= {q_in[QW-2:0], ge};
                d_reg[k]   <= {d_in[QW-2:0], 1'b0};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign quot = q_reg[QW-1];
    assign neg  = neg_reg[QW-1];

endmodule

`default_nettype wire

@@ rtl/vec3_fixed_point_alu.sv @@
`default_nettype none

// Stateless 3-vector ALU on signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default): add, sub, dot, cross, scale, divide by scalar, length, normalize, equal.
// One item is taken every cycle while the output is not held; each result (Q16.16
// by default) passes the product and element stages, the pipelined square root
// (one bit per stage), the pipelined divider (one quotient bit per stage) and the output register.
// Three lanes handle the x, y, z elements side by side and a merge stage forms dot
// and sum of squares. Results that leave the 32-bit range are clamped and reported
// as saturated; divide by zero and normalize of a zero vector give zero results with
// their own status. The whole pipeline holds while a result waits at the output.
module vec3_fixed_point_alu #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, factor
    input  wire logic [3:0]   s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // r_x, r_y, r_z, scalar_out
    output logic [1:0]        m_tuser    // status
);

    localparam int DW  = v3a_pkg::DATA_W;
    localparam int PW  = v3a_pkg::PROD_W;
    localparam int SW  = v3a_pkg::SUM_W;
    localparam int NL  = v3a_pkg::LANES;
    localparam int NS  = v3a_pkg::SQ_STAGES;
    localparam int QW  = DW + FRAC_BITS;
    localparam int NSB = NS + QW;
    localparam int LAT = 2 + NSB + 1;

    logic adv;
    logic [LAT-1:0] v_reg;

    v3a_pkg::cmd_t        cmd_in;
    logic signed [DW-1:0] a_in [NL];
    logic signed [DW-1:0] b_in [NL];
    logic signed [DW-1:0] f_in;

    assign adv      = !v_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[LAT-1];

    assign cmd_in = v3a_pkg::cmd_t'(s_tuser);
    assign f_in   = s_tdata[7*DW-1:6*DW];
    for (genvar i = 0; i < NL; i++)
    begin : g_unpack
        assign a_in[i] = s_tdata[i*DW +: DW];
        assign b_in[i] = s_tdata[(i+NL)*DW +: DW];
    end

    // Advance the valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], s_tvalid};
        end
    end

    // Lanes
    logic signed [PW-1:0] prod [NL];
    logic [DW-1:0]        elem [NL];
    logic [NL-1:0]        elem_sat;

    for (genvar i = 0; i < NL; i++)
    begin : g_lane
        v3a_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .en       (adv),
            .cmd      (cmd_in),
            .a_self   (a_in[i]),
            .a_p      (a_in[(i+1)%NL]),
            .a_q      (a_in[(i+2)%NL]),
            .b_self   (b_in[i]),
            .b_p      (b_in[(i+1)%NL]),
            .b_q      (b_in[(i+2)%NL]),
            .factor   (f_in),
            .prod     (prod[i]),
            .elem     (elem[i]),
            .elem_sat (elem_sat[i])
        );
    end

    // Stage 1 side copy
    v3a_pkg::cmd_t         cmd1_reg;
    logic [NL-1:0][DW-1:0] a1_reg;
    logic [NL-1:0][DW-1:0] b1_reg;
    logic [DW-1:0]         f1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= cmd_in;
            for (int i = 0; i < NL; i++)
            begin
                a1_reg[i] <= a_in[i];
                b1_reg[i] <= b_in[i];
            end
            f1_reg <= f_in;
        end
    end

    // Merge: dot product, sum of squares, equality
    localparam logic [DW-1:0] ONE_FX = {{(DW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [SW-1:0] dot_sum;
    logic signed [SW-1:0] dot_sh;
    v3a_pkg::sat_res_t    dot_res;
    logic [PW-1:0]        sq_sum;
    logic                 eq;
    logic [DW-1:0]        s_next;
    logic                 sat_next;

    always_comb
    begin
        dot_sum = $signed({{(SW-PW){prod[0][PW-1]}}, prod[0]})
                + $signed({{(SW-PW){prod[1][PW-1]}}, prod[1]})
                + $signed({{(SW-PW){prod[2][PW-1]}}, prod[2]});
        dot_sh  = dot_sum >>> FRAC_BITS;
        dot_res = v3a_pkg::sat32(dot_sh);
        sq_sum  = prod[0] + prod[1] + prod[2];
        eq      = (a1_reg == b1_reg);
        case (cmd1_reg)
            v3a_pkg::CMD_DOT:
            begin
                s_next   = dot_res.val;
                sat_next = dot_res.sat;
            end
            v3a_pkg::CMD_EQ:
            begin
                s_next   = eq ? ONE_FX : '0;
                sat_next = 1'b0;
            end
            default:
            begin
                s_next   = '0;
                sat_next = 1'b0;
            end
        endcase
    end

    v3a_pkg::cmd_t         cmd2_reg;
    logic [DW-1:0]         s2_reg;
    logic                  sat2_reg;
    logic [NL-1:0][DW-1:0] a2_reg;
    logic [DW-1:0]         f2_reg;
    logic [PW-1:0]         sq2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd2_reg <= cmd1_reg;
            s2_reg   <= s_next;
            sat2_reg <= sat_next;
            a2_reg   <= a1_reg;
            f2_reg   <= f1_reg;
            sq2_reg  <= sq_sum;
        end
    end

    v3a_pkg::side_t side2;

    always_comb
    begin
        side2.cmd     = cmd2_reg;
        for (int i = 0; i < NL; i++)
        begin
            side2.r[i] = elem[i];
        end
        side2.s       = s2_reg;
        side2.sat     = sat2_reg | (|elem_sat);
        side2.a       = a2_reg;
        side2.f       = f2_reg;
        side2.len     = '0;
        side2.sq_zero = (sq2_reg == '0);
    end

    // Square root of the sum of squares
    logic [DW-1:0] root;

    v3a_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .n    (sq2_reg),
        .root (root)
    );

    // Sideband delay line matching the root and divide stages
    v3a_pkg::side_t side_reg [NSB];
    v3a_pkg::side_t side_tap;

    always_comb
    begin
        side_tap     = side_reg[NS-1];
        side_tap.len = root;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side2;
            for (int k = 1; k < NSB; k++)
            begin
                if (k == NS)
                begin
                    side_reg[k] <= side_tap;
                end
                else
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // Divider lanes: by factor for divide, by length for normalize
    logic          is_norm;
    logic [DW-1:0] den_mag;
    logic          den_neg;
    logic [QW-1:0] quot [NL];
    logic [NL-1:0] qneg;

    assign is_norm = (side_tap.cmd == v3a_pkg::CMD_NORM);
    assign den_neg = is_norm ? 1'b0 : side_tap.f[DW-1];
    assign den_mag = is_norm ? side_tap.len
                   : (side_tap.f[DW-1] ? (~side_tap.f + 1'b1) : side_tap.f);

    for (genvar i = 0; i < NL; i++)
    begin : g_div
        v3a_lane_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (adv),
            .num     (side_tap.a[i]),
            .den_mag (den_mag),
            .den_neg (den_neg),
            .quot    (quot[i]),
            .neg     (qneg[i])
        );
    end

    // Final selection
    v3a_pkg::side_t        side_end;
    v3a_pkg::sat_res_t     qres [NL];
    v3a_pkg::sat_res_t     len_res;
    logic signed [SW-1:0]  qwide [NL];
    logic [NL-1:0][DW-1:0] r_next;
    logic [DW-1:0]         so_next;
    v3a_pkg::status_t      st_next;
    logic                  qsat;

    assign side_end = side_reg[NSB-1];

    always_comb
    begin
        qsat = 1'b0;
        for (int i = 0; i < NL; i++)
        begin
            qwide[i] = $signed({{(SW-QW){1'b0}}, quot[i]});
            if (qneg[i])
            begin
                qwide[i] = -qwide[i];
            end
            qres[i] = v3a_pkg::sat32(qwide[i]);
            qsat    = qsat | qres[i].sat;
        end
        len_res = v3a_pkg::sat32($signed({{(SW-DW){1'b0}}, side_end.len}));

        r_next  = '0;
        so_next = '0;
        st_next = v3a_pkg::ST_OK;
        case (side_end.cmd)
            v3a_pkg::CMD_DIV, v3a_pkg::CMD_NORM:
            begin
                if (side_end.cmd == v3a_pkg::CMD_DIV && side_end.f == '0)
                begin
                    st_next = v3a_pkg::ST_DIVZERO;
                end
                else if (side_end.cmd == v3a_pkg::CMD_NORM && side_end.sq_zero)
                begin
                    st_next = v3a_pkg::ST_ZERONORM;
                end
                else
                begin
                    for (int i = 0; i < NL; i++)
                    begin
                        r_next[i] = qres[i].val;
                    end
                    st_next = qsat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
                end
            end
            v3a_pkg::CMD_LEN:
            begin
                so_next = len_res.val;
                st_next = len_res.sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
            end
            default:
            begin
                r_next  = side_end.r;
                so_next = side_end.s;
                st_next = side_end.sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
            end
        endcase
    end

    // Output register
    logic [127:0] out_data_reg;
    logic [1:0]   out_user_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {so_next, r_next[2], r_next[1], r_next[0]};
            out_user_reg <= st_next;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    // Error results carry zero payload
    a_divzero_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == v3a_pkg::ST_DIVZERO |-> m_tdata == '0)
        else $error("divide by zero result not cleared");

    a_zeronorm_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == v3a_pkg::ST_ZERONORM |-> m_tdata == '0)
        else $error("zero normalize result not cleared");

    // A held pipeline keeps every item in place
    a_hold_chain : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("valid chain moved while held");

endmodule

`default_nettype wire
